[sv/sha1bsh_pkg.sv]
`timescale 1ns / 1ps

package sha1bsh_pkg;

	// Initial chaining values.
	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;

	// Round constants, one for each group of twenty rounds.
	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	// Marker byte that opens the padding.
	localparam logic [7:0] PAD_BYTE = 8'h80;

	// Round bookkeeping.
	localparam logic [6:0] LAST_LOAD_ROUND = 7'd15;
	localparam logic [6:0] LAST_ROUND      = 7'd79;
	localparam logic [2:0] LAST_WORD_INDEX = 3'd4;

	// Input beat payload.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       last;
	} in_item_t;

	// Output beat payload.
	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        digest_last;
	} out_item_t;

	// One message word on its way from the front end to the compression core.
	typedef struct packed {
		logic [31:0] word;
		logic        msg_end;
	} q_entry_t;

	function automatic logic [31:0] iv_word(input logic [2:0] idx);
		logic [31:0] v;
		case (idx)
			3'd0: v = H0;
			3'd1: v = H1;
			3'd2: v = H2;
			3'd3: v = H3;
			3'd4: v = H4;
			default: v = H0;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] round_k(input logic [6:0] r);
		logic [31:0] v;
		if (r < 7'd20) begin
			v = K0;
		end else if (r < 7'd40) begin
			v = K1;
		end else if (r < 7'd60) begin
			v = K2;
		end else begin
			v = K3;
		end
		return v;
	endfunction

endpackage

[sv/sha1bsh_stream_if.sv]
`timescale 1ns / 1ps

interface sha1bsh_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[sv/sha1bsh_front.sv]
`timescale 1ns / 1ps

module sha1bsh_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  sha1bsh_pkg::in_item_t in_item,
	output logic                  push_valid,
	output sha1bsh_pkg::q_entry_t push_entry,
	input  logic                  q_full
);

	localparam logic [2:0] F_IDLE  = 3'd0;
	localparam logic [2:0] F_FIRST = 3'd1;
	localparam logic [2:0] F_ZERO  = 3'd2;
	localparam logic [2:0] F_LENHI = 3'd3;
	localparam logic [2:0] F_LENLO = 3'd4;

	logic [2:0]  state_q;
	logic [5:0]  fill_q;
	logic [60:0] total_q;
	logic [3:0]  wcnt_q;
	logic [23:0] acc_q;
	logic        in_fire;
	logic        take_byte;
	logic [31:0] first_word;

	// Bytes are taken only outside padding and while the queue has room.
	assign in_ready  = (state_q == F_IDLE) && !q_full;
	assign in_fire   = in_valid && in_ready;
	assign take_byte = in_fire && in_item.byte_valid;

	// Word that holds the tail of the message and the marker byte.
	always_comb begin
		case (fill_q[1:0])
			2'd0: first_word = {sha1bsh_pkg::PAD_BYTE, 24'h000000};
			2'd1: first_word = {acc_q[23:16], sha1bsh_pkg::PAD_BYTE, 16'h0000};
			2'd2: first_word = {acc_q[23:8], sha1bsh_pkg::PAD_BYTE, 8'h00};
			2'd3: first_word = {acc_q, sha1bsh_pkg::PAD_BYTE};
			default: first_word = 32'h00000000;
		endcase
	end

	// Words toward the queue: packed message words, then the padding words.
	always_comb begin
		push_valid         = 1'b0;
		push_entry.word    = 32'h00000000;
		push_entry.msg_end = 1'b0;
		case (state_q)
			F_IDLE: begin
				if (take_byte && (fill_q[1:0] == 2'd3)) begin
					push_valid      = 1'b1;
					push_entry.word = {acc_q, in_item.data_byte};
				end
			end
			F_FIRST: begin
				push_valid      = !q_full;
				push_entry.word = first_word;
			end
			F_ZERO: begin
				push_valid = !q_full;
			end
			F_LENHI: begin
				push_valid      = !q_full;
				push_entry.word = total_q[60:29];
			end
			F_LENLO: begin
				push_valid         = !q_full;
				push_entry.word    = {total_q[28:0], 3'b000};
				push_entry.msg_end = 1'b1;
			end
			default: begin
				push_valid = 1'b0;
			end
		endcase
	end

	// Byte counting and the padding sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			fill_q  <= 6'd0;
			total_q <= 61'd0;
			wcnt_q  <= 4'd0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (take_byte) begin
						fill_q  <= fill_q + 6'd1;
						total_q <= total_q + 61'd1;
					end
					if (in_fire && in_item.last) begin
						state_q <= F_FIRST;
					end
				end
				F_FIRST: begin
					if (!q_full) begin
						wcnt_q  <= fill_q[5:2] + 4'd1;
						state_q <= (fill_q[5:2] == 4'd13) ? F_LENHI : F_ZERO;
					end
				end
				F_ZERO: begin
					if (!q_full) begin
						wcnt_q <= wcnt_q + 4'd1;
						if (wcnt_q == 4'd13) begin
							state_q <= F_LENHI;
						end
					end
				end
				F_LENHI: begin
					if (!q_full) begin
						state_q <= F_LENLO;
					end
				end
				F_LENLO: begin
					if (!q_full) begin
						state_q <= F_IDLE;
						fill_q  <= 6'd0;
						total_q <= 61'd0;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	// Partial word, most significant byte first.
	always_ff @(posedge clk) begin
		if (take_byte) begin
			case (fill_q[1:0])
				2'd0: acc_q[23:16] <= in_item.data_byte;
				2'd1: acc_q[15:8]  <= in_item.data_byte;
				2'd2: acc_q[7:0]   <= in_item.data_byte;
				default: acc_q <= acc_q;
			endcase
		end
	end

endmodule

[sv/sha1bsh_queue.sv]
`timescale 1ns / 1ps

module sha1bsh_queue #(
	parameter int DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	input  sha1bsh_pkg::q_entry_t push_entry,
	output logic                  full,
	input  logic                  pop,
	output logic                  pop_valid,
	output sha1bsh_pkg::q_entry_t pop_entry
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	sha1bsh_pkg::q_entry_t entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_entry = entry_q[rd_ptr_q];
	assign do_push   = push_valid && !full;
	assign do_pop    = pop && pop_valid;

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_entry;
		end
	end

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push_valid)
		else $error("queue: word offered while the queue is full");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> pop_valid)
		else $error("queue: word taken from an empty queue");

endmodule

[sv/sha1bsh_core.sv]
`timescale 1ns / 1ps

module sha1bsh_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pop_valid,
	input  sha1bsh_pkg::q_entry_t  pop_entry,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output sha1bsh_pkg::out_item_t out_item
);

	localparam logic [1:0] B_LOAD  = 2'd0;
	localparam logic [1:0] B_ROUND = 2'd1;
	localparam logic [1:0] B_ADD   = 2'd2;
	localparam logic [1:0] B_OUT   = 2'd3;

	logic [1:0]  bstate_q;
	logic [6:0]  rnd_q;
	logic [2:0]  oidx_q;
	logic        end_q;
	logic [31:0] hash_q [5];
	logic [31:0] v_q [5];
	logic [31:0] w_q [16];
	logic [31:0] hsum [5];
	logic        round_en;
	logic [31:0] wx;
	logic [31:0] wt;
	logic [31:0] f;
	logic [31:0] tsum;

	// A round runs on each word taken from the queue and on every expansion round.
	assign pop      = (bstate_q == B_LOAD) && pop_valid;
	assign round_en = pop || (bstate_q == B_ROUND);

	// Message schedule: the window holds the last sixteen words.
	assign wx = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign wt = (bstate_q == B_LOAD) ? pop_entry.word : {wx[30:0], wx[31]};

	// Round function and the new working word.
	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (v_q[1] & v_q[2]) ^ (~v_q[1] & v_q[3]);
		end else if ((rnd_q < 7'd40) || (rnd_q >= 7'd60)) begin
			f = v_q[1] ^ v_q[2] ^ v_q[3];
		end else begin
			f = (v_q[1] & v_q[2]) ^ (v_q[1] & v_q[3]) ^ (v_q[2] & v_q[3]);
		end
		tsum = {v_q[0][26:0], v_q[0][31:27]} + f + v_q[4] + sha1bsh_pkg::round_k(rnd_q) + wt;
	end

	// Chaining update at the end of a block.
	always_comb begin
		for (int i = 0; i < 5; i++) begin
			hsum[i] = hash_q[i] + v_q[i];
		end
	end

	// Digest beats come straight from the hash registers.
	assign out_valid            = (bstate_q == B_OUT);
	assign out_item.digest_word = hash_q[oidx_q];
	assign out_item.word_index  = oidx_q;
	assign out_item.digest_last = (oidx_q == sha1bsh_pkg::LAST_WORD_INDEX);

	// Block sequencer, working variables and hash state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bstate_q <= B_LOAD;
			rnd_q    <= 7'd0;
			oidx_q   <= 3'd0;
			end_q    <= 1'b0;
			for (int i = 0; i < 5; i++) begin
				hash_q[i] <= sha1bsh_pkg::iv_word(3'(i));
				v_q[i]    <= sha1bsh_pkg::iv_word(3'(i));
			end
		end else begin
			if (round_en) begin
				v_q[0] <= tsum;
				v_q[1] <= v_q[0];
				v_q[2] <= {v_q[1][1:0], v_q[1][31:2]};
				v_q[3] <= v_q[2];
				v_q[4] <= v_q[3];
			end
			case (bstate_q)
				B_LOAD: begin
					if (pop_valid) begin
						end_q <= pop_entry.msg_end;
						rnd_q <= rnd_q + 7'd1;
						if (rnd_q == sha1bsh_pkg::LAST_LOAD_ROUND) begin
							bstate_q <= B_ROUND;
						end
					end
				end
				B_ROUND: begin
					if (rnd_q == sha1bsh_pkg::LAST_ROUND) begin
						rnd_q    <= 7'd0;
						bstate_q <= B_ADD;
					end else begin
						rnd_q <= rnd_q + 7'd1;
					end
				end
				B_ADD: begin
					for (int i = 0; i < 5; i++) begin
						hash_q[i] <= hsum[i];
						v_q[i]    <= hsum[i];
					end
					bstate_q <= end_q ? B_OUT : B_LOAD;
				end
				B_OUT: begin
					if (out_ready) begin
						if (oidx_q == sha1bsh_pkg::LAST_WORD_INDEX) begin
							oidx_q   <= 3'd0;
							bstate_q <= B_LOAD;
							for (int i = 0; i < 5; i++) begin
								hash_q[i] <= sha1bsh_pkg::iv_word(3'(i));
								v_q[i]    <= sha1bsh_pkg::iv_word(3'(i));
							end
						end else begin
							oidx_q <= oidx_q + 3'd1;
						end
					end
				end
				default: begin
					bstate_q <= B_LOAD;
				end
			endcase
		end
	end

	// Schedule window shifts once per round.
	always_ff @(posedge clk) begin
		if (round_en) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= wt;
		end
	end

	a_restart_after_digest: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && (oidx_q == sha1bsh_pkg::LAST_WORD_INDEX))
		|=> (hash_q[0] == sha1bsh_pkg::H0) && (hash_q[4] == sha1bsh_pkg::H4)
		&& (bstate_q == B_LOAD) && (rnd_q == 7'd0))
		else $error("core: hash state not restarted after the final digest beat");

	a_expansion_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(bstate_q == B_ROUND) |-> (rnd_q > sha1bsh_pkg::LAST_LOAD_ROUND)
		&& (rnd_q <= sha1bsh_pkg::LAST_ROUND))
		else $error("core: expansion round count out of range");

	a_digest_follows_block: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(bstate_q) == B_ADD) && (oidx_q == 3'd0))
		else $error("core: digest started without a finished final block");

endmodule

[sv/sha1_byte_stream_hasher_unit.sv]
// After the last beat the front end queues 3 to 18 padding words. A block passes through
// load, round and add steps, and the first digest beat follows the final block's add step.
// The default four-word queue fills during the rounds; new bytes are then held off until the
// core takes words from the queue again.
// Reset (arst_n low, asynchronous): hash at the initial values, counts and queue empty.
`timescale 1ns / 1ps

module sha1_byte_stream_hasher_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	sha1bsh_stream_if.sink   byte_in,
	sha1bsh_stream_if.source digest_out
);

	logic                   push_valid;
	sha1bsh_pkg::q_entry_t  push_entry;
	logic                   q_full;
	logic                   pop;
	logic                   pop_valid;
	sha1bsh_pkg::q_entry_t  pop_entry;
	sha1bsh_pkg::in_item_t  in_item;
	sha1bsh_pkg::out_item_t out_item;

	// Payload repacking between the channels and the internal types.
	assign in_item.data_byte  = byte_in.payload.data_byte;
	assign in_item.byte_valid = byte_in.payload.byte_valid;
	assign in_item.last       = byte_in.payload.last;

	assign digest_out.payload.digest_word = out_item.digest_word;
	assign digest_out.payload.word_index  = out_item.word_index;
	assign digest_out.payload.digest_last = out_item.digest_last;

	// Byte packing and padding.
	sha1bsh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (byte_in.valid),
		.in_ready   (byte_in.ready),
		.in_item    (in_item),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	// Word queue between the front end and the core.
	sha1bsh_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_entry  (pop_entry)
	);

	// Compression and digest output.
	sha1bsh_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_entry (pop_entry),
		.pop       (pop),
		.out_valid (digest_out.valid),
		.out_ready (digest_out.ready),
		.out_item  (out_item)
	);

endmodule
